// ===== rtl/dael_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dael_pkg
// shared constants and types for the dual acknowledge event ring log
// ----------------------------------------------------------------------------
package dael_pkg;

    localparam int          CAPACITY_DEF = 32;
    localparam logic [15:0] LAG_RESET    = 16'd100;
    localparam logic [31:0] ID_FIRST     = 32'd1;
    localparam logic [31:0] ID_LAST      = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_ACK_A  = 2'd1,
        OP_ACK_B  = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef struct packed {
        logic        [31:0] id;
        logic        [31:0] ts;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic        [15:0] peak;
    } t_rec;

endpackage

// ===== rtl/dael_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dael_if
// valid/ready channels for command words and result words
// ----------------------------------------------------------------------------
interface dael_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  op;
    logic        [31:0] timestamp_ms;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic        [15:0] peak_level;
    logic        [31:0] ack_id;
    logic        [5:0]  max_count;

    modport source (
        output valid, op, timestamp_ms, accel_x, accel_y, accel_z,
               peak_level, ack_id, max_count,
        input  ready
    );
    modport sink (
        input  valid, op, timestamp_ms, accel_x, accel_y, accel_z,
               peak_level, ack_id, max_count,
        output ready
    );
endinterface

interface dael_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] event_id;
    logic        [31:0] rec_timestamp_ms;
    logic signed [15:0] rec_accel_x;
    logic signed [15:0] rec_accel_y;
    logic signed [15:0] rec_accel_z;
    logic        [15:0] rec_peak;
    logic               record_valid;
    logic               last_of_run;
    logic        [5:0]  pending_count;
    logic        [31:0] ack_a_id;
    logic        [31:0] ack_b_id;
    logic        [31:0] next_event_id;

    modport source (
        output valid, event_id, rec_timestamp_ms, rec_accel_x, rec_accel_y,
               rec_accel_z, rec_peak, record_valid, last_of_run, pending_count,
               ack_a_id, ack_b_id, next_event_id,
        input  ready
    );
    modport sink (
        input  valid, event_id, rec_timestamp_ms, rec_accel_x, rec_accel_y,
               rec_accel_z, rec_peak, record_valid, last_of_run, pending_count,
               ack_a_id, ack_b_id, next_event_id,
        output ready
    );
endinterface

// ===== rtl/dael_ring_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dael_ring_ram
// record store, one write port and one registered read port
// ----------------------------------------------------------------------------
module dael_ring_ram #(
    parameter  int DEPTH = dael_pkg::CAPACITY_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  dael_pkg::t_rec   i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output dael_pkg::t_rec   o_rd_data
);
    import dael_pkg::*;

    t_rec r_mem [DEPTH];
    t_rec r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/dual_ack_event_ring_log_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_ack_event_ring_log_unit
// ring log of event records with two consumer acknowledge cursors
//
// i_ev takes one command word at a time: append, acknowledge a, acknowledge b
// or read pending. o_ev returns one status word per command, or for a read
// one word per pending record up to max_count, oldest first, last_of_run on
// the final word. max_cursor_lag is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while idle, and the block does
// not enforce this. Every command ends with a walk over the record ram for
// the pending count, one entry per cycle; an advancing acknowledge first
// compacts entry by entry (ST_COMP_RD, ST_COMP_CHK) and a read then walks
// entry by entry (ST_RD_ADDR, ST_RD_DATA). A new command is taken as soon as
// the last word of the previous one sits in the output register. When the
// receiver stalls, the walk holds at the next word to send and resumes once
// the output register drains.
// Reset empties the log, sets the next id to 1, clears both cursors and sets
// the lag limit to 100. Record contents are not cleared; no clearing pass.
// ----------------------------------------------------------------------------
module dual_ack_event_ring_log_unit #(
    parameter int CAPACITY = dael_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    dael_in_if.sink     i_ev,
    dael_out_if.source  o_ev
);
    import dael_pkg::*;

    localparam int SW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > 6) ? CW : 6;
    localparam logic [SW-1:0] LAST_SLOT = SW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT   = CW'(CAPACITY);
    localparam logic [CW:0]   CAP_WIDE  = (CW + 1)'(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APP_WR,
        ST_APP_PULL,
        ST_DRAG,
        ST_COMP_RD,
        ST_COMP_CHK,
        ST_PEND,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_RD_FLUSH,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic        [31:0] event_id;
        logic        [31:0] ts;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic        [15:0] peak;
        logic               record_valid;
        logic               last_of_run;
        logic        [5:0]  pending_count;
        logic        [31:0] ack_a_id;
        logic        [31:0] ack_b_id;
        logic        [31:0] next_event_id;
    } t_res;

    t_state             r_state;
    t_op                r_op;
    logic        [31:0] r_ts;
    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic        [15:0] r_peak;
    logic        [5:0]  r_maxc;
    logic        [31:0] r_eid;
    logic        [SW-1:0] r_ws;
    logic        [CW-1:0] r_used;
    logic        [31:0] r_idc;
    logic        [31:0] r_ack_a;
    logic        [31:0] r_ack_b;
    logic        [15:0] r_lag;
    logic        [31:0] r_lo;
    logic        [CW-1:0] r_idx;
    logic               r_pv;
    logic        [CW-1:0] r_cnt;
    logic        [CW-1:0] r_nfound;
    logic               r_hold_vld;
    t_rec               r_hold;
    logic               r_out_vld;
    t_res               r_out;

    t_rec               rd_data;
    t_rec               wr_data;
    logic               rd_en;
    logic    [SW-1:0]   rd_addr;
    logic    [CW:0]     tail_sum;
    logic    [CW:0]     walk_sum;
    logic    [SW-1:0]   tail_slot;
    logic    [SW-1:0]   walk_addr;
    logic    [SW-1:0]   ws_next;
    logic               pend_go;
    logic               walk_go;
    logic               out_free;
    logic               out_load;
    logic    [31:0]     cur_hi;
    logic    [31:0]     cur_lo;
    logic    [31:0]     cur_gap;

    always_comb begin
        tail_sum = {1'b0, CW'(r_ws)} - {1'b0, r_used};
        if (CW'(r_ws) < r_used) begin
            tail_sum = tail_sum + CAP_WIDE;
        end
        tail_slot = tail_sum[SW-1:0];
        walk_sum  = {1'b0, CW'(tail_slot)} + {1'b0, r_idx};
        if (walk_sum >= CAP_WIDE) begin
            walk_sum = walk_sum - CAP_WIDE;
        end
        walk_addr = walk_sum[SW-1:0];
    end

    assign ws_next  = (r_ws == LAST_SLOT) ? '0 : r_ws + 1'b1;
    assign pend_go  = (r_idx < r_used);
    assign walk_go  = pend_go && (MW'(r_nfound) < MW'(r_maxc));
    assign out_free = !r_out_vld || o_ev.ready;
    assign out_load = out_free && ((r_state == ST_DONE) || (r_state == ST_RD_FLUSH) ||
                      ((r_state == ST_RD_DATA) && r_hold_vld && (rd_data.id > r_ack_a)));
    assign cur_hi   = (r_ack_a > r_ack_b) ? r_ack_a : r_ack_b;
    assign cur_lo   = (r_ack_a < r_ack_b) ? r_ack_a : r_ack_b;
    assign cur_gap  = cur_hi - cur_lo;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        case (r_state)
            ST_APP_WR: begin
                rd_en   = (r_used == CAP_CNT);
                rd_addr = ws_next;
            end
            ST_COMP_RD: begin
                rd_en   = (r_used != '0);
                rd_addr = tail_slot;
            end
            ST_PEND: begin
                rd_en   = pend_go;
                rd_addr = walk_addr;
            end
            ST_RD_ADDR: begin
                rd_en   = walk_go;
                rd_addr = walk_addr;
            end
            default: begin
                rd_en   = 1'b0;
                rd_addr = '0;
            end
        endcase
    end

    assign wr_data = '{id: r_idc, ts: r_ts, ax: r_ax, ay: r_ay, az: r_az, peak: r_peak};

    dael_ring_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == ST_APP_WR),
        .i_wr_addr (r_ws),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_ws       <= '0;
            r_used     <= '0;
            r_idc      <= ID_FIRST;
            r_ack_a    <= '0;
            r_ack_b    <= '0;
            r_lag      <= LAG_RESET;
            r_pv       <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_lag <= i_cfg_wr_data;
            end
            if (r_out_vld && o_ev.ready && !out_load) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_ev.valid) begin
                        r_op       <= t_op'(i_ev.op);
                        r_ts       <= i_ev.timestamp_ms;
                        r_ax       <= i_ev.accel_x;
                        r_ay       <= i_ev.accel_y;
                        r_az       <= i_ev.accel_z;
                        r_peak     <= i_ev.peak_level;
                        r_maxc     <= i_ev.max_count;
                        r_eid      <= '0;
                        r_idx      <= '0;
                        r_cnt      <= '0;
                        r_pv       <= 1'b0;
                        r_nfound   <= '0;
                        r_hold_vld <= 1'b0;
                        case (t_op'(i_ev.op))
                            OP_APPEND: begin
                                r_state <= ST_APP_WR;
                            end
                            OP_ACK_A: begin
                                if (i_ev.ack_id > r_ack_a) begin
                                    r_ack_a <= i_ev.ack_id;
                                    r_state <= ST_DRAG;
                                end else begin
                                    r_state <= ST_PEND;
                                end
                            end
                            OP_ACK_B: begin
                                if (i_ev.ack_id > r_ack_b) begin
                                    r_ack_b <= i_ev.ack_id;
                                    r_state <= ST_DRAG;
                                end else begin
                                    r_state <= ST_PEND;
                                end
                            end
                            default: begin
                                r_state <= ST_PEND;
                            end
                        endcase
                    end
                end

                ST_APP_WR: begin
                    r_eid <= r_idc;
                    r_idc <= (r_idc == ID_LAST) ? ID_FIRST : r_idc + 32'd1;
                    r_ws  <= ws_next;
                    if (r_used != CAP_CNT) begin
                        r_used  <= r_used + 1'b1;
                        r_state <= ST_PEND;
                    end else begin
                        r_state <= ST_APP_PULL;
                    end
                end

                // ring was full: pull cursors up to oldest id minus one
                ST_APP_PULL: begin
                    if ({1'b0, r_ack_a} + 33'd1 < {1'b0, rd_data.id}) begin
                        r_ack_a <= rd_data.id - 32'd1;
                    end
                    if ({1'b0, r_ack_b} + 33'd1 < {1'b0, rd_data.id}) begin
                        r_ack_b <= rd_data.id - 32'd1;
                    end
                    r_state <= ST_PEND;
                end

                ST_DRAG: begin
                    if (cur_gap > {16'd0, r_lag}) begin
                        r_ack_a <= cur_hi;
                        r_ack_b <= cur_hi;
                        r_lo    <= cur_hi;
                    end else begin
                        r_lo    <= cur_lo;
                    end
                    r_state <= ST_COMP_RD;
                end

                ST_COMP_RD: begin
                    r_state <= (r_used == '0) ? ST_PEND : ST_COMP_CHK;
                end

                ST_COMP_CHK: begin
                    if (rd_data.id <= r_lo) begin
                        r_used  <= r_used - 1'b1;
                        r_state <= ST_COMP_RD;
                    end else begin
                        r_state <= ST_PEND;
                    end
                end

                // pipelined count of records above cursor a
                ST_PEND: begin
                    r_pv <= pend_go;
                    if (pend_go) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pv && (rd_data.id > r_ack_a)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (!pend_go && !r_pv) begin
                        r_idx   <= '0;
                        r_state <= (r_op == OP_READ) ? ST_RD_ADDR : ST_DONE;
                    end
                end

                ST_RD_ADDR: begin
                    if (walk_go) begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= ST_RD_DATA;
                    end else if (r_hold_vld) begin
                        r_state <= ST_RD_FLUSH;
                    end else begin
                        r_state <= ST_DONE;
                    end
                end

                // one record held back so the final word can carry last_of_run
                ST_RD_DATA: begin
                    if (rd_data.id > r_ack_a) begin
                        if (!r_hold_vld) begin
                            r_hold     <= rd_data;
                            r_hold_vld <= 1'b1;
                            r_nfound   <= r_nfound + 1'b1;
                            r_state    <= ST_RD_ADDR;
                        end else if (out_free) begin
                            r_out_vld <= 1'b1;
                            r_out     <= '{event_id: r_hold.id, ts: r_hold.ts,
                                           ax: r_hold.ax, ay: r_hold.ay, az: r_hold.az,
                                           peak: r_hold.peak, record_valid: 1'b1,
                                           last_of_run: 1'b0, pending_count: 6'(r_cnt),
                                           ack_a_id: r_ack_a, ack_b_id: r_ack_b,
                                           next_event_id: r_idc};
                            r_hold    <= rd_data;
                            r_nfound  <= r_nfound + 1'b1;
                            r_state   <= ST_RD_ADDR;
                        end
                    end else begin
                        r_state <= ST_RD_ADDR;
                    end
                end

                ST_RD_FLUSH: begin
                    if (out_free) begin
                        r_out_vld  <= 1'b1;
                        r_out      <= '{event_id: r_hold.id, ts: r_hold.ts,
                                        ax: r_hold.ax, ay: r_hold.ay, az: r_hold.az,
                                        peak: r_hold.peak, record_valid: 1'b1,
                                        last_of_run: 1'b1, pending_count: 6'(r_cnt),
                                        ack_a_id: r_ack_a, ack_b_id: r_ack_b,
                                        next_event_id: r_idc};
                        r_hold_vld <= 1'b0;
                        r_state    <= ST_IDLE;
                    end
                end

                ST_DONE: begin
                    if (out_free) begin
                        r_out_vld <= 1'b1;
                        r_out     <= '{event_id: r_eid, ts: '0, ax: '0, ay: '0, az: '0,
                                       peak: '0, record_valid: 1'b0, last_of_run: 1'b1,
                                       pending_count: 6'(r_cnt), ack_a_id: r_ack_a,
                                       ack_b_id: r_ack_b, next_event_id: r_idc};
                        r_state   <= ST_IDLE;
                    end
                end

                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign i_ev.ready            = (r_state == ST_IDLE);
    assign o_ev.valid            = r_out_vld;
    assign o_ev.event_id         = r_out.event_id;
    assign o_ev.rec_timestamp_ms = r_out.ts;
    assign o_ev.rec_accel_x      = r_out.ax;
    assign o_ev.rec_accel_y      = r_out.ay;
    assign o_ev.rec_accel_z      = r_out.az;
    assign o_ev.rec_peak         = r_out.peak;
    assign o_ev.record_valid     = r_out.record_valid;
    assign o_ev.last_of_run      = r_out.last_of_run;
    assign o_ev.pending_count    = r_out.pending_count;
    assign o_ev.ack_a_id         = r_out.ack_a_id;
    assign o_ev.ack_b_id         = r_out.ack_b_id;
    assign o_ev.next_event_id    = r_out.next_event_id;

endmodule

// ===== rtl/dael_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dael_chk
// port level checks for the ring log, bound to the top level
// ----------------------------------------------------------------------------
module dael_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic        [31:0] i_event_id,
    input logic        [31:0] i_rec_ts,
    input logic signed [15:0] i_rec_ax,
    input logic signed [15:0] i_rec_ay,
    input logic signed [15:0] i_rec_az,
    input logic        [15:0] i_rec_peak,
    input logic               i_record_valid,
    input logic               i_last_of_run,
    input logic        [31:0] i_ack_a_id
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_status_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_record_valid |->
            i_last_of_run && (i_rec_ts == 32'd0) && (i_rec_ax == 16'sd0) &&
            (i_rec_ay == 16'sd0) && (i_rec_az == 16'sd0) && (i_rec_peak == 16'd0))
        else $error("status word with record fields or not last");

    a_rec_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_record_valid |-> (i_event_id > i_ack_a_id))
        else $error("read returned a record already acknowledged by a");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second command taken while one is in work");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind dual_ack_event_ring_log_unit dael_chk u_dael_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_ev.valid),
    .i_in_ready     (i_ev.ready),
    .i_out_valid    (o_ev.valid),
    .i_out_ready    (o_ev.ready),
    .i_event_id     (o_ev.event_id),
    .i_rec_ts       (o_ev.rec_timestamp_ms),
    .i_rec_ax       (o_ev.rec_accel_x),
    .i_rec_ay       (o_ev.rec_accel_y),
    .i_rec_az       (o_ev.rec_accel_z),
    .i_rec_peak     (o_ev.rec_peak),
    .i_record_valid (o_ev.record_valid),
    .i_last_of_run  (o_ev.last_of_run),
    .i_ack_a_id     (o_ev.ack_a_id)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the dual acknowledge event ring log against a cycle-free model
//
// A model of the log (ring, write slot, fill level, id counter, both cursors
// and the lag limit) predicts every result word of each accepted command.
// A separate process takes the result words, with random stalls, and
// compares them field by field in order. Directed tests cover the empty log,
// field extremes, acknowledges that do not advance, compaction, lag drag and
// cursors at the top of the id range. Random traffic then runs under several
// lag limits, under a long receiver hold-off and in a stretch with no idling.
// ----------------------------------------------------------------------------
module testbench;
    import dael_pkg::*;

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 4_000_000;
    localparam int MAX_SHOWN    = 10;

    typedef struct packed {
        t_op                op;
        logic        [31:0] ts;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic        [15:0] peak;
        logic        [31:0] ack;
        logic        [5:0]  maxc;
    } t_cmd;

    typedef struct packed {
        logic        [31:0] event_id;
        logic        [31:0] ts;
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic        [15:0] peak;
        logic               rvalid;
        logic               last;
        logic        [5:0]  pend;
        logic        [31:0] ack_a;
        logic        [31:0] ack_b;
        logic        [31:0] next_id;
    } t_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;

    dael_in_if  cmd_if ();
    dael_out_if res_if ();

    dual_ack_event_ring_log_unit #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ev          (cmd_if),
        .o_ev          (res_if)
    );

    // log model state
    t_rec        log_ring [DEPTH];
    int unsigned log_wr;
    int unsigned log_used;
    logic [31:0] log_next_id;
    logic [31:0] log_ack_a;
    logic [31:0] log_ack_b;
    logic [15:0] log_lag;

    t_word  expected_q [$];
    int     mismatches = 0;
    bit     quiet      = 1'b0;
    int     hold_req   = 0;
    longint cycles     = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("testbench failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned log_tail();
        return (log_wr + DEPTH - (log_used % (DEPTH + 1))) % DEPTH;
    endfunction

    function automatic logic [5:0] log_pending();
        int unsigned t;
        int unsigned n;
        t = log_tail();
        n = 0;
        for (int unsigned i = 0; i < log_used && i < DEPTH; i++)
            if (log_ring[(t + i) % DEPTH].id > log_ack_a)
                n++;
        return n[5:0];
    endfunction

    function automatic t_word status_word(logic [31:0] eid);
        t_word w;
        w         = '0;
        w.event_id = eid;
        w.last    = 1'b1;
        w.pend    = log_pending();
        w.ack_a   = log_ack_a;
        w.ack_b   = log_ack_b;
        w.next_id = log_next_id;
        return w;
    endfunction

    function automatic void log_compact();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = (log_ack_a < log_ack_b) ? log_ack_a : log_ack_b;
        hi = (log_ack_a > log_ack_b) ? log_ack_a : log_ack_b;
        if (hi - lo > {16'b0, log_lag}) begin
            lo        = hi;
            log_ack_a = hi;
            log_ack_b = hi;
        end
        while (log_used > 0 && log_ring[log_tail()].id <= lo)
            log_used--;
    endfunction

    function automatic void predict_words(t_cmd c);
        t_word           rd [DEPTH];
        t_rec            r;
        int unsigned     n;
        int unsigned     t;
        logic [31:0]     eid;
        longint unsigned oldest;
        n   = 0;
        eid = '0;
        case (c.op)
            OP_APPEND: begin
                r.id   = log_next_id;
                r.ts   = c.ts;
                r.ax   = c.ax;
                r.ay   = c.ay;
                r.az   = c.az;
                r.peak = c.peak;
                eid    = log_next_id;
                log_next_id = (log_next_id == ID_LAST) ? ID_FIRST : log_next_id + 32'd1;
                log_ring[log_wr] = r;
                log_wr = (log_wr + 1) % DEPTH;
                if (log_used < DEPTH) begin
                    log_used++;
                end else begin
                    // overwrite pulls lagging cursors up to oldest id minus one
                    oldest = 64'(log_ring[log_tail()].id);
                    if (64'(log_ack_a) + 64'd1 < oldest)
                        log_ack_a = 32'(oldest - 64'd1);
                    if (64'(log_ack_b) + 64'd1 < oldest)
                        log_ack_b = 32'(oldest - 64'd1);
                end
            end
            OP_ACK_A: begin
                if (c.ack > log_ack_a) begin
                    log_ack_a = c.ack;
                    log_compact();
                end
            end
            OP_ACK_B: begin
                if (c.ack > log_ack_b) begin
                    log_ack_b = c.ack;
                    log_compact();
                end
            end
            OP_READ: begin
                t = log_tail();
                for (int unsigned i = 0; i < log_used && i < DEPTH && n < c.maxc; i++) begin
                    r = log_ring[(t + i) % DEPTH];
                    if (r.id > log_ack_a) begin
                        rd[n]        = status_word(r.id);
                        rd[n].ts     = r.ts;
                        rd[n].ax     = r.ax;
                        rd[n].ay     = r.ay;
                        rd[n].az     = r.az;
                        rd[n].peak   = r.peak;
                        rd[n].rvalid = 1'b1;
                        rd[n].last   = 1'b0;
                        n++;
                    end
                end
            end
            default: begin
            end
        endcase
        if (n == 0) begin
            expected_q.push_back(status_word(eid));
        end else begin
            rd[n - 1].last = 1'b1;
            for (int unsigned i = 0; i < n; i++)
                expected_q.push_back(rd[i]);
        end
    endfunction

    function automatic t_cmd noise_cmd(t_op op);
        t_cmd c;
        c.op   = op;
        c.ts   = $urandom;
        c.ax   = 16'($urandom);
        c.ay   = 16'($urandom);
        c.az   = 16'($urandom);
        c.peak = 16'($urandom);
        c.ack  = $urandom;
        c.maxc = 6'($urandom_range(0, 32));
        return c;
    endfunction

    function automatic t_cmd w_append(logic [31:0] ts, logic signed [15:0] ax,
                                      logic signed [15:0] ay, logic signed [15:0] az,
                                      logic [15:0] peak);
        t_cmd c;
        c      = noise_cmd(OP_APPEND);
        c.ts   = ts;
        c.ax   = ax;
        c.ay   = ay;
        c.az   = az;
        c.peak = peak;
        return c;
    endfunction

    function automatic t_cmd w_ack(t_op op, logic [31:0] id);
        t_cmd c;
        c     = noise_cmd(op);
        c.ack = id;
        return c;
    endfunction

    function automatic t_cmd w_read(logic [5:0] n);
        t_cmd c;
        c      = noise_cmd(OP_READ);
        c.maxc = n;
        return c;
    endfunction

    function automatic t_cmd random_word(int app_pct);
        t_cmd        c;
        int          r;
        int          s;
        logic [31:0] lo;
        logic [31:0] cur;
        r  = $urandom_range(0, 99);
        lo = (log_ack_a < log_ack_b) ? log_ack_a : log_ack_b;
        if (r < app_pct) begin
            c = noise_cmd(OP_APPEND);
            if ($urandom_range(0, 7) == 0) begin
                c.ax   = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
                c.ay   = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
                c.az   = ($urandom_range(0, 1) != 0) ? 16'sh8000 : 16'sh7fff;
                c.peak = ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hffff;
                c.ts   = ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hffff_ffff;
            end
        end else if (r < app_pct + (100 - app_pct) * 2 / 3) begin
            c   = noise_cmd(($urandom_range(0, 1) != 0) ? OP_ACK_A : OP_ACK_B);
            cur = (c.op == OP_ACK_A) ? log_ack_a : log_ack_b;
            s   = $urandom_range(0, 99);
            if (s < 70)
                c.ack = $urandom_range(lo, log_next_id);
            else if (s < 85)
                c.ack = $urandom_range(0, cur);
            else
                c.ack = log_next_id + 32'($urandom_range(0, 3));
        end else begin
            c = noise_cmd(OP_READ);
            s = $urandom_range(0, 99);
            if (s < 10)
                c.maxc = 6'd0;
            else if (s < 30)
                c.maxc = 6'd32;
            else
                c.maxc = 6'($urandom_range(1, 32));
        end
        return c;
    endfunction

    task automatic send_word(t_cmd c);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_if.valid        <= 1'b1;
        cmd_if.op           <= c.op;
        cmd_if.timestamp_ms <= c.ts;
        cmd_if.accel_x      <= c.ax;
        cmd_if.accel_y      <= c.ay;
        cmd_if.accel_z      <= c.az;
        cmd_if.peak_level   <= c.peak;
        cmd_if.ack_id       <= c.ack;
        cmd_if.max_count    <= c.maxc;
        do @(posedge i_clk); while (!cmd_if.ready);
        predict_words(c);
    endtask

    // sender pauses until every expected word has come back
    task automatic settle();
        cmd_if.valid <= 1'b0;
        do @(posedge i_clk); while (expected_q.size() != 0);
    endtask

    task automatic set_lag(logic [15:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        log_lag = v;
    endtask

    task automatic random_phase(int n, int app_pct);
        repeat (n) send_word(random_word(app_pct));
        settle();
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic test_empty_log();
        send_word(w_read(6'd5));
        send_word(w_ack(OP_ACK_A, 32'd0));
        send_word(w_ack(OP_ACK_B, 32'd0));
        send_word(w_read(6'd0));
        settle();
    endtask

    task automatic test_append_read();
        send_word(w_append(32'd0, 16'sh8000, 16'sh7fff, 16'sd0, 16'h0000));
        send_word(w_append(32'hffff_ffff, 16'sh7fff, 16'sh8000, -16'sd1, 16'hffff));
        send_word(noise_cmd(OP_APPEND));
        send_word(noise_cmd(OP_APPEND));
        send_word(w_read(6'd0));
        send_word(w_read(6'd32));
        send_word(w_read(6'd1));
        settle();
    endtask

    task automatic test_ack_compaction();
        send_word(w_ack(OP_ACK_A, 32'd2));
        send_word(w_ack(OP_ACK_A, 32'd2));
        send_word(w_ack(OP_ACK_B, 32'd1));
        // id beyond anything assigned yet
        send_word(w_ack(OP_ACK_B, log_next_id + 32'd1));
        send_word(w_read(6'd32));
        settle();
    endtask

    task automatic test_lag_drag();
        set_lag(16'd0);
        send_word(noise_cmd(OP_APPEND));
        send_word(w_ack(OP_ACK_A, log_next_id - 32'd1));
        send_word(w_read(6'd32));
        send_word(noise_cmd(OP_APPEND));
        send_word(noise_cmd(OP_APPEND));
        send_word(w_ack(OP_ACK_A, log_next_id + 32'd3));
        send_word(w_read(6'd32));
        settle();
    endtask

    task automatic test_random_traffic();
        set_lag(LAG_RESET);
        random_phase(100, 40);
        set_lag(16'd0);
        random_phase(80, 40);
        set_lag(16'hffff);
        random_phase(80, 70);
        set_lag(16'd5);
        random_phase(80, 50);
    endtask

    task automatic test_backpressure();
        quiet    = 1'b1;
        hold_req = 400;
        repeat (40) send_word(noise_cmd(OP_APPEND));
        send_word(w_read(6'd32));
        quiet = 1'b0;
        settle();
    endtask

    task automatic test_idle_free_burst();
        quiet = 1'b1;
        repeat (40) send_word(random_word(50));
        settle();
        quiet = 1'b0;
    endtask

    task automatic test_cursor_extremes();
        set_lag(LAG_RESET);
        send_word(w_ack(OP_ACK_A, 32'h8000_0000));
        send_word(w_ack(OP_ACK_B, 32'hffff_ffff));
        send_word(w_ack(OP_ACK_A, 32'hffff_ffff));
        send_word(w_ack(OP_ACK_B, 32'd0));
        // overwrite with cursors at the top of the id range
        repeat (34) send_word(noise_cmd(OP_APPEND));
        send_word(w_read(6'd32));
        settle();
    endtask

    initial begin : result_sink
        int    stall_left;
        int    hold_left;
        t_word exp_w;
        stall_left = 0;
        hold_left  = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result word, event_id %h", res_if.event_id);
                end else begin
                    exp_w = expected_q.pop_front();
                    check_field("event_id", exp_w.event_id, res_if.event_id);
                    check_field("rec_timestamp_ms", exp_w.ts, res_if.rec_timestamp_ms);
                    check_field("rec_accel_x", 32'(exp_w.ax), 32'(res_if.rec_accel_x));
                    check_field("rec_accel_y", 32'(exp_w.ay), 32'(res_if.rec_accel_y));
                    check_field("rec_accel_z", 32'(exp_w.az), 32'(res_if.rec_accel_z));
                    check_field("rec_peak", 32'(exp_w.peak), 32'(res_if.rec_peak));
                    check_field("record_valid", 32'(exp_w.rvalid), 32'(res_if.record_valid));
                    check_field("last_of_run", 32'(exp_w.last), 32'(res_if.last_of_run));
                    check_field("pending_count", 32'(exp_w.pend), 32'(res_if.pending_count));
                    check_field("ack_a_id", exp_w.ack_a, res_if.ack_a_id);
                    check_field("ack_b_id", exp_w.ack_b, res_if.ack_b_id);
                    check_field("next_event_id", exp_w.next_id, res_if.next_event_id);
                end
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 99) < 20)
                    stall_left = pick_gap();
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_wr_en         <= 1'b0;
        i_cfg_wr_data       <= '0;
        cmd_if.valid        <= 1'b0;
        cmd_if.op           <= OP_APPEND;
        cmd_if.timestamp_ms <= '0;
        cmd_if.accel_x      <= '0;
        cmd_if.accel_y      <= '0;
        cmd_if.accel_z      <= '0;
        cmd_if.peak_level   <= '0;
        cmd_if.ack_id       <= '0;
        cmd_if.max_count    <= '0;
        for (int i = 0; i < DEPTH; i++)
            log_ring[i] = '0;
        log_wr      = 0;
        log_used    = 0;
        log_next_id = ID_FIRST;
        log_ack_a   = '0;
        log_ack_b   = '0;
        log_lag     = LAG_RESET;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_log();
        test_append_read();
        test_ack_compaction();
        test_lag_drag();
        test_random_traffic();
        test_backpressure();
        test_idle_free_burst();
        test_cursor_extremes();

        settle();
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
